// ----- sv/channel_pedestal_averager_defines.svh -----
// Assertion macros shared by the pedestal averager RTL.
`ifndef CHANNEL_PEDESTAL_AVERAGER_DEFINES_SVH
`define CHANNEL_PEDESTAL_AVERAGER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/cpa_pkg.sv -----
// Shared types, constants and codes of the pedestal averager.
`timescale 1ns / 1ps
package cpa_pkg;

  // Parameter defaults
  localparam int NUM_MODULES_DEF  = 64;
  localparam int NUM_CHANNELS_DEF = 64;

  // Field widths
  localparam int MODULE_W = 6;
  localparam int CHAN_W   = 6;
  localparam int CHARGE_W = 12;
  localparam int SUM_W    = 32;
  localparam int TALLY_W  = 20;
  localparam int QUO_W    = 12;

  // Width for the entry index product and for the range compare
  localparam int IDX_CALC_W = 17;
  localparam int RANGE_W    = 9;

  // Divider step counter
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_W - 1);

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  // Input codes
  localparam logic       MODE_ACCUM = 1'b0;
  localparam logic       MODE_READ  = 1'b1;
  localparam logic [1:0] PKT_ADC    = 2'd1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ACCUM     = 2'd0,
    ST_READ      = 2'd1,
    ST_NOT_ADC   = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  // One pedestal entry
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [TALLY_W-1:0] tally;
  } entry_t;

endpackage

// ----- sv/channel_pedestal_averager.sv -----
// Top level: sequencer for per-channel pedestal accumulate and read-clear.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid in_ready mode pkt_kind            | sink
//          | module_req channel charge                  |
//  out     | out_valid out_ready status pedestal        | source
//          | hit_count                                  |
//
// Accumulate, ignored hit and empty read: the item is captured, then the
// registered read port of the entry memory feeds lookup and write-back.
// A read of an entry with hits adds the shared divider; one item in flight.
// After reset a clearing pass zeroes every entry, one per cycle, all
// NUM_MODULES * NUM_CHANNELS of them (4096 by default); in_ready stays low.
// A result waits in the output register while the next item is taken; the
// sequencer holds a finished result only if that register is still full.
`timescale 1ns / 1ps
`include "channel_pedestal_averager_defines.svh"
module channel_pedestal_averager #(
  parameter int NUM_MODULES  = cpa_pkg::NUM_MODULES_DEF,
  parameter int NUM_CHANNELS = cpa_pkg::NUM_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [1:0]                   pkt_kind,
  input  logic [cpa_pkg::MODULE_W-1:0] module_req,
  input  logic [cpa_pkg::CHAN_W-1:0]   channel,
  input  logic [cpa_pkg::CHARGE_W-1:0] charge,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [cpa_pkg::QUO_W-1:0]    pedestal,
  output logic [cpa_pkg::TALLY_W-1:0]  hit_count
);
  import cpa_pkg::*;

  localparam int ENTRIES = NUM_MODULES * NUM_CHANNELS;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DIVIDE,
    S_DONE
  } state_t;

  state_t state;

  // Captured item
  logic                req_mode;
  logic [1:0]          req_ptype;
  logic [CHARGE_W-1:0] req_charge;
  logic [AW-1:0]       req_idx;
  logic                req_in_range;

  // Pending result
  status_t             res_status;
  logic [QUO_W-1:0]    res_ped;
  logic [TALLY_W-1:0]  res_count;

  logic [AW-1:0]       clr_idx;

  // Entry index and range of the incoming item
  logic [IDX_CALC_W-1:0] in_idx_full;
  logic [AW-1:0]         in_idx;
  logic                  in_in_range;

  assign in_idx_full = IDX_CALC_W'(module_req) * IDX_CALC_W'(NUM_CHANNELS)
                     + IDX_CALC_W'(channel);
  assign in_idx      = in_idx_full[AW-1:0];
  assign in_in_range = (RANGE_W'(module_req) < RANGE_W'(NUM_MODULES))
                    && (RANGE_W'(channel) < RANGE_W'(NUM_CHANNELS));

  assign in_ready = (state == S_IDLE);

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // Memory ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  entry_t        rd_data;

  assign rd_en = in_valid && in_ready;

  cpa_store #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (in_idx),
    .rd_data (rd_data)
  );

  // Lookup-cycle decision on the fetched entry
  status_t            lk_status;
  logic [TALLY_W-1:0] lk_count;
  logic               lk_wr;
  entry_t             lk_data;
  logic               lk_div;

  always_comb begin
    lk_status = ST_NOT_ADC;
    lk_count  = rd_data.tally;
    lk_wr     = 1'b0;
    lk_data   = '0;
    lk_div    = 1'b0;
    priority if (!req_in_range) begin
      lk_status = (req_mode == MODE_READ) ? ST_READ : ST_NOT_ADC;
      lk_count  = '0;
    end else if (req_mode == MODE_READ) begin
      lk_status = ST_READ;
      lk_wr     = 1'b1;
      lk_div    = (rd_data.tally != '0);
    end else if (req_ptype != PKT_ADC) begin
      lk_status = ST_NOT_ADC;
    end else if (rd_data.tally == TALLY_MAX) begin
      lk_status = ST_SATURATED;
    end else begin
      lk_status     = ST_ACCUM;
      lk_wr         = 1'b1;
      lk_data.sum   = rd_data.sum + SUM_W'(req_charge);
      lk_data.tally = rd_data.tally + 1'b1;
    end
  end

  // Write mux: clearing pass or write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = req_idx;
    wr_data = lk_data;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = '0;
      end
      S_LOOKUP: begin
        wr_en = (state == S_LOOKUP) && lk_wr;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Shared divider for the read path
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [QUO_W-1:0] div_quo;

  assign div_start = (state == S_LOOKUP) && lk_div;

  cpa_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_data.sum),
    .divisor  (rd_data.tally),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_mode     <= mode;
            req_ptype    <= pkt_kind;
            req_charge   <= charge;
            req_idx      <= in_idx;
            req_in_range <= in_in_range;
            state        <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          res_status <= lk_status;
          res_ped    <= '0;
          res_count  <= lk_count;
          if (lk_div) begin
            state <= S_DIVIDE;
          end else if (out_free) begin
            status    <= lk_status;
            pedestal  <= '0;
            hit_count <= lk_count;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_DONE;
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            res_ped <= div_quo;
            if (out_free) begin
              status    <= res_status;
              pedestal  <= div_quo;
              hit_count <= res_count;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            status    <= res_status;
            pedestal  <= res_ped;
            hit_count <= res_count;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // One item in flight: an accepted item closes the input next cycle
  `CPA_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready,
    "input stayed open after an item was accepted")

  // The divider only runs while the sequencer waits on it
  `CPA_ASSERT_NOW(a_div_owned, clk, rst, div_busy || div_done, state == S_DIVIDE,
    "divider active outside the divide state")

  // A result appears only after a lookup, a division or a held result
  `CPA_ASSERT_NOW(a_result_source, clk, rst, $rose(out_valid),
    $past(state) == S_LOOKUP || $past(state) == S_DIVIDE || $past(state) == S_DONE,
    "result raised without a finished item")

endmodule

// ----- sv/cpa_store.sv -----
// Pedestal entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
module cpa_store #(
  parameter int DEPTH = cpa_pkg::NUM_MODULES_DEF * cpa_pkg::NUM_CHANNELS_DEF,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  cpa_pkg::entry_t  wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output cpa_pkg::entry_t  rd_data
);
  import cpa_pkg::*;

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/cpa_divider.sv -----
// Iterative restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module cpa_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cpa_pkg::SUM_W-1:0]   dividend,
  input  logic [cpa_pkg::TALLY_W-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [cpa_pkg::QUO_W-1:0]   quotient
);
  import cpa_pkg::*;

  logic [TALLY_W-1:0] rem;
  logic [QUO_W-1:0]   quo;
  logic [STEP_W-1:0]  step;
  logic [TALLY_W:0]   trial;
  logic [TALLY_W:0]   diff;
  logic               fits;

  // The mean never exceeds the largest charge, so the upper dividend bits
  // start below the divisor and only the low quotient bits need steps.
  assign trial = {rem, quo[QUO_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  assign quotient = quo;

  // Shift in one dividend bit, subtract when the divisor fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend[SUM_W-1:QUO_W];
        quo  <= dividend[QUO_W-1:0];
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? diff[TALLY_W-1:0] : trial[TALLY_W-1:0];
        quo  <= {quo[QUO_W-2:0], fits};
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the per-channel pedestal averager.
`timescale 1ns / 1ps
module tb;
  import cpa_pkg::*;

  // Packet types that never accumulate
  localparam logic [1:0] PKT_DISC  = 2'd0;
  localparam logic [1:0] PKT_TRIG  = 2'd2;
  localparam logic [1:0] PKT_SPARE = 2'd3;

  localparam int ENTRIES     = NUM_MODULES_DEF * NUM_CHANNELS_DEF;
  localparam int MAX_WAIT    = 14;
  localparam int SETTLE_CYC  = 40;
  localparam int RANDOM_ITEMS = 1900;

  typedef struct {
    status_t               st;
    logic [QUO_W-1:0]      ped;
    logic [TALLY_W-1:0]    cnt;
  } ped_result_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                mode;
  logic [1:0]          pkt_kind;
  logic [MODULE_W-1:0] module_req;
  logic [CHAN_W-1:0]   channel;
  logic [CHARGE_W-1:0] charge;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          status;
  logic [QUO_W-1:0]    pedestal;
  logic [TALLY_W-1:0]  hit_count;

  // Shadow copy of the entry stores
  logic [SUM_W-1:0]    shadow_sum   [ENTRIES];
  logic [TALLY_W-1:0]  shadow_tally [ENTRIES];

  ped_result_t pending_pedestal_results [$];

  int  error_count;
  int  items_sent;
  int  results_checked;
  int  filled_reads;
  int  saw_input_stall;
  bit  in_idle;
  bit  out_idle;
  int  stall_hold;

  channel_pedestal_averager DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .pkt_kind    (pkt_kind),
    .module_req  (module_req),
    .channel     (channel),
    .charge      (charge),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .pedestal    (pedestal),
    .hit_count   (hit_count)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Apply one access to the shadow stores and return the result it yields
  function automatic ped_result_t predict_entry_access(
    input logic                m,
    input logic [1:0]          pt,
    input logic [MODULE_W-1:0] md,
    input logic [CHAN_W-1:0]   ch,
    input logic [CHARGE_W-1:0] chg
  );
    ped_result_t      r;
    int               idx;
    logic [TALLY_W-1:0] cnt;
    logic [QUO_W-1:0] quo;
    r.st  = ST_NOT_ADC;
    r.ped = '0;
    r.cnt = '0;
    // Out-of-range entries are never touched
    if (md >= NUM_MODULES_DEF || ch >= NUM_CHANNELS_DEF) begin
      if (m == MODE_READ) r.st = ST_READ;
      return r;
    end
    idx = int'(md) * NUM_CHANNELS_DEF + int'(ch);
    cnt = shadow_tally[idx];
    r.cnt = cnt;
    if (m == MODE_READ) begin
      quo = '0;
      if (cnt != 0) begin
        quo = QUO_W'(shadow_sum[idx] / cnt);
        filled_reads++;
      end
      r.st  = ST_READ;
      r.ped = quo;
      shadow_sum[idx]   = '0;
      shadow_tally[idx] = '0;
    end else if (pt != PKT_ADC) begin
      r.st = ST_NOT_ADC;
    end else if (cnt == TALLY_MAX) begin
      r.st = ST_SATURATED;
    end else begin
      r.st = ST_ACCUM;
      shadow_sum[idx]   = shadow_sum[idx] + SUM_W'(chg);
      shadow_tally[idx] = cnt + 1'b1;
    end
    return r;
  endfunction

  // Offer one item, hold it until taken, then log its expected result
  task automatic send_item(
    input logic                m,
    input logic [1:0]          pt,
    input logic [MODULE_W-1:0] md,
    input logic [CHAN_W-1:0]   ch,
    input logic [CHARGE_W-1:0] chg
  );
    int gap;
    gap = in_idle ? $urandom_range(MAX_WAIT, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    pkt_kind    <= pt;
    module_req  <= md;
    channel     <= ch;
    charge      <= chg;
    @(posedge clk);
    while (!in_ready) begin
      saw_input_stall++;
      @(posedge clk);
    end
    pending_pedestal_results = {pending_pedestal_results,
                                predict_entry_access(m, pt, md, ch, chg)};
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and let every outstanding result come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_pedestal_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random stall per result, plus an optional long hold-off
  initial begin
    int wait_n;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      wait_n = stall_hold + (out_idle ? $urandom_range(MAX_WAIT, 0) : 0);
      stall_hold = 0;
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && stall_hold == 0);
      @(negedge clk);
    end
  end

  // Compare each delivered result with the oldest expectation
  always @(posedge clk) begin
    ped_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (pending_pedestal_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: status %0d ped %0d cnt %0d",
                                  status, pedestal, hit_count));
      end else begin
        want = pending_pedestal_results.pop_front();
        if (status !== want.st)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
        if (pedestal !== want.ped)
          report_mismatch($sformatf("pedestal %0d, expected %0d", pedestal, want.ped));
        if (hit_count !== want.cnt)
          report_mismatch($sformatf("hit_count %0d, expected %0d", hit_count, want.cnt));
      end
    end
  end

  // Hand-picked accesses: empty reads, extremes, ignored types, rounding
  task automatic test_directed_cases();
    in_idle  = 1'b1;
    out_idle = 1'b1;
    send_item(MODE_READ,  PKT_ADC,   6'd0,  6'd0,  12'd0);
    send_item(MODE_READ,  PKT_SPARE, 6'd63, 6'd63, 12'd4095);
    send_item(MODE_ACCUM, PKT_ADC,   6'd63, 6'd63, 12'd4095);
    send_item(MODE_ACCUM, PKT_ADC,   6'd63, 6'd63, 12'd0);
    send_item(MODE_ACCUM, PKT_DISC,  6'd63, 6'd63, 12'd4095);
    send_item(MODE_ACCUM, PKT_TRIG,  6'd63, 6'd63, 12'd123);
    send_item(MODE_ACCUM, PKT_SPARE, 6'd63, 6'd63, 12'd4095);
    send_item(MODE_READ,  PKT_DISC,  6'd63, 6'd63, 12'd77);
    send_item(MODE_READ,  PKT_TRIG,  6'd63, 6'd63, 12'd0);
    // floor of 1.5
    send_item(MODE_ACCUM, PKT_ADC,   6'd0,  6'd63, 12'd1);
    send_item(MODE_ACCUM, PKT_ADC,   6'd0,  6'd63, 12'd2);
    send_item(MODE_READ,  PKT_ADC,   6'd0,  6'd63, 12'd4095);
    repeat (3) send_item(MODE_ACCUM, PKT_ADC, 6'd63, 6'd0, 12'd4095);
    send_item(MODE_READ,  PKT_SPARE, 6'd63, 6'd0,  12'd0);
    send_item(MODE_ACCUM, PKT_ADC,   6'd0,  6'd0,  12'd0);
    send_item(MODE_READ,  PKT_ADC,   6'd0,  6'd0,  12'd0);
    send_item(MODE_ACCUM, PKT_ADC,   6'd42, 6'd21, 12'd2730);
    send_item(MODE_ACCUM, PKT_ADC,   6'd21, 6'd42, 12'd1365);
    send_item(MODE_READ,  PKT_ADC,   6'd42, 6'd21, 12'd0);
    send_item(MODE_READ,  PKT_ADC,   6'd21, 6'd42, 12'd0);
    wait_drain();
  endtask

  // Baseline runs on a few hot entries with reads mixed in, plus noise
  task automatic test_random_traffic();
    logic [MODULE_W-1:0] hot_mod [6];
    logic [CHAN_W-1:0]   hot_ch  [6];
    logic [CHARGE_W-1:0] chg;
    logic [1:0]          pt;
    int                  counted;
    int                  iter;
    int                  pick;
    int                  r;
    int                  pattern;
    counted = 0;
    iter    = 0;
    while (counted < RANDOM_ITEMS) begin
      // New hot entries and a new idle pattern every stretch
      if (iter % 100 == 0) begin
        pattern  = $urandom_range(3, 0);
        in_idle  = pattern[0];
        out_idle = pattern[1];
        foreach (hot_mod[i]) begin
          hot_mod[i] = MODULE_W'($urandom_range(63, 0));
          hot_ch[i]  = CHAN_W'($urandom_range(63, 0));
        end
      end
      iter++;
      pick = $urandom_range(5, 0);
      r    = $urandom_range(99, 0);
      chg  = CHARGE_W'($urandom_range(4095, 0));
      if ($urandom_range(9, 0) == 0) chg = $urandom_range(1, 0) ? 12'd4095 : 12'd0;
      if (r < 70) begin
        send_item(MODE_ACCUM, PKT_ADC, hot_mod[pick], hot_ch[pick], chg);
        counted++;
      end else if (r < 80) begin
        case ($urandom_range(2, 0))
          0:       pt = PKT_DISC;
          1:       pt = PKT_TRIG;
          default: pt = PKT_SPARE;
        endcase
        send_item(MODE_ACCUM, pt, MODULE_W'($urandom_range(63, 0)),
                  CHAN_W'($urandom_range(63, 0)), chg);
        counted++;
      end else if (r < 92) begin
        send_item(MODE_READ, 2'($urandom_range(3, 0)), hot_mod[pick], hot_ch[pick], chg);
        counted++;
      end else begin
        pt = 2'($urandom_range(3, 0));
        send_item(1'($urandom_range(1, 0)), pt, MODULE_W'($urandom_range(63, 0)),
                  CHAN_W'($urandom_range(63, 0)), chg);
        counted++;
      end
    end
    wait_drain();
  endtask

  // Hold the output off long enough that the block backs up its input
  task automatic test_output_backpressure();
    int i;
    in_idle    = 1'b0;
    out_idle   = 1'b0;
    stall_hold = 400;
    for (i = 0; i < 60; i++) begin
      if (i % 10 == 9)
        send_item(MODE_READ, PKT_ADC, 6'd5, 6'd9, 12'd0);
      else
        send_item(MODE_ACCUM, PKT_ADC, 6'd5, 6'd9, CHARGE_W'($urandom_range(4095, 0)));
    end
    out_idle = 1'b1;
    wait_drain();
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    mode            = MODE_ACCUM;
    pkt_kind        = PKT_DISC;
    module_req      = '0;
    channel         = '0;
    charge          = '0;
    in_idle         = 1'b0;
    out_idle        = 1'b0;
    stall_hold      = 0;
    error_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    filled_reads    = 0;
    saw_input_stall = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_sum[i]   = '0;
      shadow_tally[i] = '0;
    end
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    test_random_traffic();
    test_output_backpressure();

    $display("Run covered %0d items and %0d checked results, %0d of them reads of filled entries,",
             items_sent, results_checked, filled_reads);
    $display("with %0d cycles of input stall under random and long output hold-off.",
             saw_input_stall);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
